[src/mcitb_pkg.sv]
// Package with the codes and constants of the interval timer bank.
`default_nettype none
package mcitb_pkg;

  localparam int NUM_SLOTS_DEFAULT = 16;
  localparam int SLOT_FIELD_LIMIT  = 16;
  localparam logic [4:0] MAX_COUNT = 5'd31;

  // Command codes carried in the op field of an input item.
  typedef enum logic [3:0] {
    OP_TICK      = 4'd0,
    OP_CREATE    = 4'd1,
    OP_DELETE    = 4'd2,
    OP_START     = 4'd3,
    OP_PAUSE     = 4'd4,
    OP_STOP      = 4'd5,
    OP_RESET     = 4'd6,
    OP_SET_IVAL  = 4'd7,
    OP_SET_MODE  = 4'd8,
    OP_SET_COUNT = 4'd9,
    OP_QUERY     = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    RS_STOPPED = 2'd0,
    RS_RUNNING = 2'd1,
    RS_WAITING = 2'd2,
    RS_FREE    = 2'd3
  } run_state_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SLOT = 2'd1,
    ST_BAD_CNT  = 2'd2,
    ST_NO_SLOT  = 2'd3
  } status_t;

  localparam logic KIND_REPLY    = 1'b0;
  localparam logic KIND_OVERFLOW = 1'b1;

endpackage
`default_nettype wire

[src/multi_channel_interval_timer_bank_unit.sv]
// Interval timer bank: slot storage, command decode and the tick scan sequencer.
// A command item passes S_CMD, which loads its reply into the output register; no new
// item is taken before the return to S_IDLE. A tick item runs S_SCAN over the BANK
// slots through the shared adder and interval compare, then S_END for the tick-end
// item; BANK is NUM_SLOTS capped at 16. Results wait while the output register is
// full. Synchronous reset marks every slot free and empties the output.
`default_nettype none
module multi_channel_interval_timer_bank_unit
  import mcitb_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input items: op [3:0], slot [7:4], amount [39:8], mode_byte [47:40].
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,
  // Result items: slot_out [3:0], status [5:4], run_state [7:6],
  // elapsed [39:8], interval_out [71:40], mode_out [79:72], freed [80].
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata,
  // Result kind: kind [0].
  output logic             m_tuser,
  output logic             m_tlast
);

  // The slot field is four bits wide, so the bank never holds more than 16 slots.
  localparam int BANK = (NUM_SLOTS < SLOT_FIELD_LIMIT) ? NUM_SLOTS : SLOT_FIELD_LIMIT;
  localparam int IW   = (BANK > 1) ? $clog2(BANK) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(BANK - 1);

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMD  = 4'b0010,
    S_SCAN = 4'b0100,
    S_END  = 4'b1000
  } state_t;

  state_t state;
  logic [IW-1:0] idx;

  // Captured input item.
  logic [3:0]  in_op;
  logic [3:0]  in_slot;
  logic [31:0] in_amount;
  logic [7:0]  in_mb;

  // Slot storage. Only the used flags need a reset: every other field of a
  // slot is written by create before the slot can be read.
  logic [BANK-1:0] used;
  logic [1:0]  slot_rs [BANK];
  logic [31:0] slot_el [BANK];
  logic [31:0] slot_iv [BANK];
  logic [7:0]  slot_md [BANK];

  // Output register.
  logic        o_kind;
  logic [3:0]  o_slot;
  logic [1:0]  o_status;
  logic [1:0]  o_rs;
  logic [31:0] o_el;
  logic [31:0] o_iv;
  logic [7:0]  o_md;
  logic        o_freed;
  logic        o_last;

  // Values for the next result item.
  logic        n_kind;
  logic [3:0]  n_slot;
  logic [1:0]  n_status;
  logic [1:0]  n_rs;
  logic [31:0] n_el;
  logic [31:0] n_iv;
  logic [7:0]  n_md;
  logic        n_freed;
  logic        n_last;

  logic          out_free;
  logic          load_out;
  logic          adv;
  logic [IW-1:0] cmd_idx;
  logic [IW-1:0] rd_idx;
  logic [1:0]    r_rs;
  logic [31:0]   r_el;
  logic [31:0]   r_iv;
  logic [7:0]    r_md;

  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [1:0]    wr_rs;
  logic [31:0]   wr_el;
  logic [31:0]   wr_iv;
  logic [7:0]    wr_md;
  logic          used_set;
  logic          used_clr;

  // Shared arithmetic: one adder and one compare against the interval.
  logic [31:0] sum;
  logic        hit;
  logic [4:0]  cnt_dec;
  logic        counting;
  logic        gone;

  logic          slot_ok;
  logic [IW-1:0] free_idx;
  logic          free_found;

  // Lowest free slot, found by a priority encoder over the used flags.
  function automatic logic [IW:0] lowest_free(input logic [BANK-1:0] u);
    logic [IW:0] r;
    r = '0;
    for (int i = BANK - 1; i >= 0; i--) begin
      if (!u[i]) begin
        r = {1'b1, IW'(i)};
      end
    end
    return r;
  endfunction

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign m_tuser  = o_kind;
  assign m_tlast  = o_last;
  assign m_tdata  = {7'b0, o_freed, o_md, o_iv, o_el, o_rs, o_status, o_slot};

  assign cmd_idx = in_slot[IW-1:0];
  assign rd_idx  = (state == S_SCAN) ? idx : cmd_idx;
  assign r_rs    = slot_rs[rd_idx];
  assign r_el    = slot_el[rd_idx];
  assign r_iv    = slot_iv[rd_idx];
  assign r_md    = slot_md[rd_idx];

  assign sum      = r_el + in_amount;
  assign hit      = (sum >= r_iv);
  // A remaining count of zero counts as one.
  assign cnt_dec  = (r_md[7:3] == 5'd0) ? 5'd0 : r_md[7:3] - 5'd1;
  assign counting = !r_md[1];
  assign gone     = counting && (cnt_dec == 5'd0);

  assign slot_ok = (int'(in_slot) < BANK) && used[cmd_idx];
  assign {free_found, free_idx} = lowest_free(used);

  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = rd_idx;
    wr_rs    = r_rs;
    wr_el    = r_el;
    wr_iv    = r_iv;
    wr_md    = r_md;
    used_set = 1'b0;
    used_clr = 1'b0;
    load_out = 1'b0;
    adv      = 1'b0;
    n_kind   = KIND_REPLY;
    n_slot   = '0;
    n_status = ST_OK;
    n_rs     = RS_STOPPED;
    n_el     = '0;
    n_iv     = '0;
    n_md     = '0;
    n_freed  = 1'b0;
    n_last   = 1'b1;
    case (state)
      S_SCAN: begin
        if (!used[idx] || r_rs != RS_RUNNING) begin
          adv = 1'b1;
        end else if (!hit) begin
          wr_en = 1'b1;
          wr_el = sum;
          adv   = 1'b1;
        end else if (out_free) begin
          // Overflow: the slot waits, restarts at zero (auto-reload), or is freed.
          wr_en    = 1'b1;
          adv      = 1'b1;
          load_out = 1'b1;
          n_kind   = KIND_OVERFLOW;
          n_last   = 1'b0;
          n_slot   = 4'(idx);
          n_iv     = r_iv;
          n_el     = r_md[2] ? 32'd0 : sum;
          n_md     = (counting && !gone) ? {cnt_dec, r_md[2:0]} : r_md;
          if (gone) begin
            used_clr = 1'b1;
            wr_rs    = RS_STOPPED;
            n_rs     = RS_FREE;
            n_freed  = 1'b1;
          end else begin
            n_rs  = r_md[2] ? RS_RUNNING : RS_WAITING;
            wr_rs = n_rs;
            wr_el = n_el;
            wr_md = n_md;
          end
        end
      end
      S_END: begin
        load_out = out_free;
      end
      S_CMD: begin
        if (out_free) begin
          load_out = 1'b1;
          if (in_op == OP_CREATE) begin
            if (in_amount == 32'd0 || !free_found) begin
              n_status = ST_NO_SLOT;
            end else begin
              wr_en    = 1'b1;
              wr_idx   = free_idx;
              used_set = 1'b1;
              wr_rs    = in_mb[0] ? RS_RUNNING : RS_STOPPED;
              wr_el    = '0;
              wr_iv    = in_amount;
              wr_md    = in_mb;
              n_slot   = 4'(free_idx);
              n_rs     = wr_rs;
              n_iv     = in_amount;
              n_md     = in_mb;
            end
          end else if (in_op > OP_QUERY || !slot_ok) begin
            n_slot   = in_slot;
            n_status = ST_BAD_SLOT;
          end else if (in_op == OP_DELETE) begin
            wr_en    = 1'b1;
            wr_rs    = RS_STOPPED;
            used_clr = 1'b1;
            n_slot   = in_slot;
            n_rs     = RS_FREE;
          end else begin
            wr_en = 1'b1;
            case (in_op)
              OP_START: wr_rs = RS_RUNNING;
              OP_PAUSE: wr_rs = RS_WAITING;
              OP_STOP: begin
                wr_rs = RS_STOPPED;
                wr_el = '0;
              end
              OP_RESET: begin
                wr_rs = RS_RUNNING;
                wr_el = '0;
              end
              OP_SET_IVAL: wr_iv = in_amount;
              OP_SET_MODE: wr_md = in_mb;
              OP_SET_COUNT: begin
                if (in_mb == 8'd0 || in_mb > {3'b0, MAX_COUNT}) begin
                  n_status = ST_BAD_CNT;
                end else begin
                  wr_md = {in_mb[4:0], r_md[2:0]};
                end
              end
              default: ;
            endcase
            n_slot = in_slot;
            n_rs   = wr_rs;
            n_el   = wr_el;
            n_iv   = wr_iv;
            n_md   = wr_md;
          end
        end
      end
      default: ;
    endcase
  end

  // Slot payload storage: one write per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_rs[wr_idx] <= wr_rs;
      slot_el[wr_idx] <= wr_el;
      slot_iv[wr_idx] <= wr_iv;
      slot_md[wr_idx] <= wr_md;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_kind   <= n_kind;
      o_slot   <= n_slot;
      o_status <= n_status;
      o_rs     <= n_rs;
      o_el     <= n_el;
      o_iv     <= n_iv;
      o_md     <= n_md;
      o_freed  <= n_freed;
      o_last   <= n_last;
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op     <= s_tdata[3:0];
      in_slot   <= s_tdata[7:4];
      in_amount <= s_tdata[39:8];
      in_mb     <= s_tdata[47:40];
    end
  end

  // Sequencer, used flags and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      used     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (used_set) begin
        used[wr_idx] <= 1'b1;
      end else if (used_clr) begin
        used[wr_idx] <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            idx   <= '0;
            state <= (s_tdata[3:0] == OP_TICK) ? S_SCAN : S_CMD;
          end
        end
        S_SCAN: begin
          if (adv) begin
            if (idx == LAST_IDX) begin
              state <= S_END;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_END: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_CMD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[tb/multi_channel_interval_timer_bank_unit_tb.sv]
// Testbench for the interval timer bank: a directed command table, random traffic and a predictor.
`timescale 1ns / 100ps

module multi_channel_interval_timer_bank_unit_tb;
  import mcitb_pkg::*;

  localparam int BANK        = 16;
  localparam int N_DIRECTED  = 25;
  localparam int N_RANDOM    = 450;
  localparam int CALM_FROM   = 390;
  localparam int DRAIN_AT    = 200;
  localparam int FILL_UNTIL  = 150;
  localparam int CYCLE_LIMIT = 600000;
  // Op codes above OP_QUERY are not commands; the block must refuse them.
  localparam logic [3:0] OP_UNUSED = 4'd15;

  // One result item as the block reports it.
  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    status_t     status;
    run_state_t  rs;
    logic [31:0] elapsed;
    logic [31:0] interval;
    logic [7:0]  mode;
    logic        freed;
    logic        last;
  } timer_result_t;

  // One row of the directed table. Where known is set, the reply is typed
  // in here: kind 0, elapsed 0, freed 0 and last 1 are implied.
  typedef struct packed {
    logic [3:0]  op;
    logic [3:0]  slot;
    logic [31:0] amount;
    logic [7:0]  mode_byte;
    logic        known;
    logic [3:0]  x_slot;
    status_t     x_status;
    run_state_t  x_rs;
    logic [31:0] x_ival;
    logic [7:0]  x_mode;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  multi_channel_interval_timer_bank_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Shadow copy of the slot bank, kept in step with every accepted item.
  logic        slot_used  [BANK];
  run_state_t  slot_rs    [BANK];
  logic [31:0] slot_count [BANK];
  logic [31:0] slot_ival  [BANK];
  logic [7:0]  slot_mode  [BANK];

  // Replies, overflow events and tick-end items still owed by the block, oldest first.
  timer_result_t pending_replies [$];

  int  fail_count  = 0;
  int  cycle_count = 0;
  int  stall_left  = 0;
  bit  calm        = 1'b0;

  stim_row_t directed_rows [N_DIRECTED];

  initial begin
    for (int s = 0; s < BANK; s++) begin
      slot_used[s]  = 1'b0;
      slot_rs[s]    = RS_STOPPED;
      slot_count[s] = '0;
      slot_ival[s]  = '0;
      slot_mode[s]  = '0;
    end
  end

  function automatic timer_result_t slot_reply(input int s, input status_t st);
    timer_result_t r;
    r          = '0;
    r.kind     = KIND_REPLY;
    r.slot     = 4'(s);
    r.status   = st;
    r.rs       = slot_rs[s];
    r.elapsed  = slot_count[s];
    r.interval = slot_ival[s];
    r.mode     = slot_mode[s];
    r.last     = 1'b1;
    return r;
  endfunction

  function automatic void release_slot(input int s);
    slot_used[s]  = 1'b0;
    slot_rs[s]    = RS_STOPPED;
    slot_count[s] = '0;
    slot_ival[s]  = '0;
    slot_mode[s]  = '0;
  endfunction

  // Works out every result that one command or tick causes and queues them.
  function automatic void predict_bank_step(input logic [3:0] op, input logic [3:0] sl,
                                            input logic [31:0] amt, input logic [7:0] mb);
    timer_result_t r;
    int            free_idx;
    logic [4:0]    cnt;
    logic          gone;
    r = '0;
    if (op == OP_TICK) begin
      // Slots are scanned in rising order; each overflow gives one event.
      for (int s = 0; s < BANK; s++) begin
        if (slot_used[s] && slot_rs[s] == RS_RUNNING) begin
          slot_count[s] = slot_count[s] + amt;
          if (slot_count[s] >= slot_ival[s]) begin
            gone = 1'b0;
            slot_rs[s] = RS_WAITING;
            if (slot_mode[s][2]) begin
              slot_count[s] = '0;
              slot_rs[s] = RS_RUNNING;
            end
            if (!slot_mode[s][1]) begin
              // A remaining count of zero behaves as one.
              cnt = slot_mode[s][7:3];
              if (cnt == 0) cnt = 5'd1;
              cnt = cnt - 5'd1;
              if (cnt == 0) gone = 1'b1;
              else slot_mode[s][7:3] = cnt;
            end
            r          = '0;
            r.kind     = KIND_OVERFLOW;
            r.slot     = 4'(s);
            r.status   = ST_OK;
            r.elapsed  = slot_count[s];
            r.interval = slot_ival[s];
            r.mode     = slot_mode[s];
            if (gone) begin
              r.rs    = RS_FREE;
              r.freed = 1'b1;
              release_slot(s);
            end else begin
              r.rs = slot_rs[s];
            end
            pending_replies.push_back(r);
          end
        end
      end
      r      = '0;
      r.last = 1'b1;
      pending_replies.push_back(r);
    end else if (op == OP_CREATE) begin
      free_idx = -1;
      for (int s = BANK - 1; s >= 0; s--) begin
        if (!slot_used[s]) free_idx = s;
      end
      if (amt == 0 || free_idx < 0) begin
        r.status = ST_NO_SLOT;
        r.last   = 1'b1;
        pending_replies.push_back(r);
      end else begin
        slot_used[free_idx]  = 1'b1;
        slot_count[free_idx] = '0;
        slot_ival[free_idx]  = amt;
        slot_mode[free_idx]  = mb;
        slot_rs[free_idx]    = mb[0] ? RS_RUNNING : RS_STOPPED;
        pending_replies.push_back(slot_reply(free_idx, ST_OK));
      end
    end else if (op > OP_QUERY || !slot_used[sl]) begin
      r.slot   = sl;
      r.status = ST_BAD_SLOT;
      r.last   = 1'b1;
      pending_replies.push_back(r);
    end else if (op == OP_DELETE) begin
      release_slot(sl);
      r.slot   = sl;
      r.rs     = RS_FREE;
      r.last   = 1'b1;
      pending_replies.push_back(r);
    end else if (op == OP_SET_COUNT && (mb == 0 || mb > 8'(MAX_COUNT))) begin
      pending_replies.push_back(slot_reply(sl, ST_BAD_CNT));
    end else begin
      case (op)
        OP_START: slot_rs[sl] = RS_RUNNING;
        OP_PAUSE: slot_rs[sl] = RS_WAITING;
        OP_STOP: begin
          slot_rs[sl]    = RS_STOPPED;
          slot_count[sl] = '0;
        end
        OP_RESET: begin
          slot_rs[sl]    = RS_RUNNING;
          slot_count[sl] = '0;
        end
        OP_SET_IVAL:  slot_ival[sl] = amt;
        OP_SET_MODE:  slot_mode[sl] = mb;
        OP_SET_COUNT: slot_mode[sl] = {mb[4:0], slot_mode[sl][2:0]};
        default: ;
      endcase
      pending_replies.push_back(slot_reply(sl, ST_OK));
    end
  endfunction

  // Builds one random item. During the fill phase creates dominate so that
  // the bank runs out of free slots now and then.
  function automatic logic [47:0] random_item(input bit filling);
    int          pick;
    int          create_end;
    logic [3:0]  op;
    logic [3:0]  sl;
    logic [31:0] amt;
    logic [7:0]  mb;
    int          used_list [$];
    for (int s = 0; s < BANK; s++) begin
      if (slot_used[s]) used_list.push_back(s);
    end
    amt = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(1, 150));
    mb  = 8'($urandom_range(255));
    if (used_list.size() != 0 && $urandom_range(99) < 85) begin
      sl = 4'(used_list[$urandom_range(used_list.size() - 1)]);
    end else begin
      sl = 4'($urandom_range(15));
    end
    create_end = filling ? 60 : 44;
    pick = $urandom_range(99);
    if (pick < (filling ? 20 : 24)) begin
      op = OP_TICK;
      case ($urandom_range(9))
        0: amt = $urandom;
        1: amt = 32'hFFFF_FFFF - 32'($urandom_range(40));
        default: amt = 32'($urandom_range(60));
      endcase
    end else if (pick < create_end) begin
      op = OP_CREATE;
      if ($urandom_range(11) == 0) amt = '0;
      if ($urandom_range(3) != 0) mb[0] = 1'b1;
    end else if (pick < create_end + (filling ? 2 : 7)) begin
      op = OP_DELETE;
    end else begin
      pick = $urandom_range(99);
      if (pick < 12) op = OP_START;
      else if (pick < 22) op = OP_PAUSE;
      else if (pick < 32) op = OP_STOP;
      else if (pick < 42) op = OP_RESET;
      else if (pick < 54) begin
        op = OP_SET_IVAL;
        if ($urandom_range(7) == 0) amt = '0;
      end else if (pick < 66) op = OP_SET_MODE;
      else if (pick < 80) begin
        op = OP_SET_COUNT;
        case ($urandom_range(9))
          0: mb = '0;
          1: mb = 8'($urandom_range(32, 255));
          default: mb = 8'($urandom_range(1, 31));
        endcase
      end else if (pick < 93) op = OP_QUERY;
      else op = 4'($urandom_range(11, 15));
    end
    return {mb, amt, sl, op};
  endfunction

  // Offers one item and waits for the handshake. Afterwards the sender may
  // go quiet for a random burst, or until everything owed has come back.
  task automatic push_item(input logic [47:0] d, input bit drain_after,
                           input bit typed_valid, input timer_result_t typed);
    int gap;
    s_tdata  <= d;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_bank_step(d[3:0], d[7:4], d[39:8], d[47:40]);
    if (typed_valid) pending_replies[pending_replies.size() - 1] = typed;
    gap = (!calm && $urandom_range(3) == 0) ? $urandom_range(1, 11) : 0;
    if (gap != 0 || drain_after) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain_after && pending_replies.size() != 0) @(posedge clk);
    end
  endtask

  // The receiver stalls in random bursts, except near the end.
  always @(posedge clk) begin
    if (calm) begin
      m_tready <= 1'b1;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic void note_mismatch(input string what, input timer_result_t want,
                                        input timer_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s: expected kind=%0d slot=%0d st=%0d rs=%0d el=%h iv=%h md=%h fr=%0d last=%0d",
               what, want.kind, want.slot, want.status, want.rs, want.elapsed,
               want.interval, want.mode, want.freed, want.last);
      $display("%s: actual   kind=%0d slot=%0d st=%0d rs=%0d el=%h iv=%h md=%h fr=%0d last=%0d",
               what, got.kind, got.slot, got.status, got.rs, got.elapsed,
               got.interval, got.mode, got.freed, got.last);
    end
  endfunction

  // Every accepted result is held against the oldest owed one.
  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind     = m_tuser;
      got.slot     = m_tdata[3:0];
      got.status   = status_t'(m_tdata[5:4]);
      got.rs       = run_state_t'(m_tdata[7:6]);
      got.elapsed  = m_tdata[39:8];
      got.interval = m_tdata[71:40];
      got.mode     = m_tdata[79:72];
      got.freed    = m_tdata[80];
      got.last     = m_tlast;
      if (pending_replies.size() == 0) begin
        note_mismatch("unexpected item", '0, got);
      end else begin
        want = pending_replies.pop_front();
        if (got.kind !== want.kind || got.slot !== want.slot || got.status !== want.status ||
            got.rs !== want.rs || got.elapsed !== want.elapsed ||
            got.interval !== want.interval || got.mode !== want.mode ||
            got.freed !== want.freed || got.last !== want.last) begin
          note_mismatch("mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multi_channel_interval_timer_bank_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    timer_result_t typed;
    // Extremes of amount and mode, refused commands, wrap of the elapsed
    // count, zero count acting as one, a zero interval, auto-reload on a
    // slot that is freed anyway, and a slot left waiting after an overflow.
    directed_rows = '{
      '{OP_QUERY,    4'd0,  32'd0,         8'h00, 1'b1, 4'd0,  ST_BAD_SLOT, RS_STOPPED,
        32'd0,         8'h00},
      '{OP_UNUSED,   4'd5,  32'hFFFF_FFFF, 8'hFF, 1'b1, 4'd5,  ST_BAD_SLOT, RS_STOPPED,
        32'd0,         8'h00},
      '{OP_CREATE,   4'd0,  32'd0,         8'h01, 1'b1, 4'd0,  ST_NO_SLOT,  RS_STOPPED,
        32'd0,         8'h00},
      '{OP_CREATE,   4'd9,  32'd100,       8'h01, 1'b1, 4'd0,  ST_OK,       RS_RUNNING,
        32'd100,       8'h01},
      '{OP_CREATE,   4'd0,  32'hFFFF_FFFF, 8'hFF, 1'b1, 4'd1,  ST_OK,       RS_RUNNING,
        32'hFFFF_FFFF, 8'hFF},
      '{OP_CREATE,   4'd0,  32'd1,         8'h06, 1'b1, 4'd2,  ST_OK,       RS_STOPPED,
        32'd1,         8'h06},
      '{OP_START,    4'd2,  32'd0,         8'h00, 1'b0, 4'd0,  ST_OK, RS_STOPPED, 32'd0, 8'h00},
      '{OP_TICK,     4'hA,  32'd100,       8'h00, 1'b0, 4'd0,  ST_OK, RS_STOPPED, 32'd0, 8'h00},
      '{OP_TICK,     4'h0,  32'hFFFF_FFFF, 8'h00, 1'b0, 4'd0,  ST_OK, RS_STOPPED, 32'd0, 8'h00},
      '{OP_SET_IVAL, 4'd1,  32'd0,         8'h00, 1'b0, 4'd0,  ST_OK, RS_STOPPED, 32'd0, 8'h00},
      '{OP_TICK,     4'hF,  32'd0,         8'hFF, 1'b0, 4'd0,  ST_OK, RS_STOPPED, 32'd0, 8'h00},
      '{OP_SET_COUNT, 4'd1, 32'd0,         8'd0,  1'b0, 4'd0,  ST_OK, RS_STOPPED, 32'd0, 8'h00},
      '{OP_SET_COUNT, 4'd1, 32'd0,         8'd32, 1'b0, 4'd0,  ST_OK, RS_STOPPED, 32'd0, 8'h00},
      '{OP_SET_COUNT, 4'd1, 32'd0,         8'd31, 1'b0, 4'd0,  ST_OK, RS_STOPPED, 32'd0, 8'h00},
      '{OP_SET_MODE, 4'd1,  32'd0,         8'h0C, 1'b0, 4'd0,  ST_OK, RS_STOPPED, 32'd0, 8'h00},
      '{OP_TICK,     4'd3,  32'd5,         8'h00, 1'b0, 4'd0,  ST_OK, RS_STOPPED, 32'd0, 8'h00},
      '{OP_PAUSE,    4'd2,  32'd0,         8'h00, 1'b0, 4'd0,  ST_OK, RS_STOPPED, 32'd0, 8'h00},
      '{OP_TICK,     4'd0,  32'd7,         8'h00, 1'b0, 4'd0,  ST_OK, RS_STOPPED, 32'd0, 8'h00},
      '{OP_STOP,     4'd2,  32'd0,         8'h00, 1'b0, 4'd0,  ST_OK, RS_STOPPED, 32'd0, 8'h00},
      '{OP_RESET,    4'd2,  32'd0,         8'h00, 1'b0, 4'd0,  ST_OK, RS_STOPPED, 32'd0, 8'h00},
      '{OP_DELETE,   4'd2,  32'd0,         8'h00, 1'b1, 4'd2,  ST_OK,       RS_FREE,
        32'd0,         8'h00},
      '{OP_QUERY,    4'd15, 32'd0,         8'h00, 1'b1, 4'd15, ST_BAD_SLOT, RS_STOPPED,
        32'd0,         8'h00},
      '{OP_QUERY,    4'd2,  32'd0,         8'h00, 1'b1, 4'd2,  ST_BAD_SLOT, RS_STOPPED,
        32'd0,         8'h00},
      '{OP_CREATE,   4'd0,  32'd3,         8'h11, 1'b1, 4'd0,  ST_OK,       RS_RUNNING,
        32'd3,         8'h11},
      '{OP_TICK,     4'd0,  32'd4,         8'h00, 1'b0, 4'd0,  ST_OK, RS_STOPPED, 32'd0, 8'h00}
    };

    // Reset is held at the start of the run and never asserted again.
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      typed          = '0;
      typed.kind     = KIND_REPLY;
      typed.slot     = directed_rows[i].x_slot;
      typed.status   = directed_rows[i].x_status;
      typed.rs       = directed_rows[i].x_rs;
      typed.interval = directed_rows[i].x_ival;
      typed.mode     = directed_rows[i].x_mode;
      typed.last     = 1'b1;
      push_item({directed_rows[i].mode_byte, directed_rows[i].amount,
                 directed_rows[i].slot, directed_rows[i].op},
                1'b0, directed_rows[i].known, typed);
    end

    // Random traffic; midway and after the last item the sender holds off until
    // everything owed has arrived, and the final stretch runs without any idling.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == CALM_FROM) calm = 1'b1;
      push_item(random_item(i < FILL_UNTIL), (i == DRAIN_AT) || (i == N_RANDOM - 1),
                1'b0, '0);
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("multi_channel_interval_timer_bank_unit_tb OK");
    end else begin
      $display("multi_channel_interval_timer_bank_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
src/mcitb_pkg.sv
src/multi_channel_interval_timer_bank_unit.sv
tb/multi_channel_interval_timer_bank_unit_tb.sv
